>>> design/assert_macros.svh
// Assertion macros used by the RTL file of the pen digitizer parser.
// Each macro expands to one labeled concurrent assertion on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define PDPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define PDPP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/pdpp_pkg.sv
// Types and constants for the pen digitizer packet parser.
// No dependencies.
package pdpp_pkg;

  localparam logic [3:0] PKT_LAST_IDX     = 4'd8;   // bytes stored before the ninth arrives
  localparam logic [3:0] CFG_REG_ENABLED  = 4'd0;
  localparam logic [3:0] CFG_REG_THRESH   = 4'd1;
  localparam logic [9:0] THRESH_RESET     = 10'd10;

  // Result item, lowest field in the lowest bits.
  typedef struct packed {
    logic        pad;
    logic        eraser_active;
    logic        side_button_b;
    logic        side_button_a;
    logic        touching;
    logic [9:0]  tip_pressure;
    logic [15:0] pos_y;
    logic [15:0] pos_x;
    logic        in_range;
  } pen_report_t;

endpackage

>>> design/pen_digitizer_packet_parser.sv
// Pen digitizer packet parser: assembles 9-byte packets and decodes pen reports.
// Depends on pdpp_pkg and assert_macros.svh.
//
//  channel   | signals                              | item
//  ----------+--------------------------------------+---------------------------
//  s_axis    | s_axis_tvalid/tready/tdata[7:0]      | one received byte
//  m_axis    | m_axis_tvalid/tready/tdata[47:0]     | one pen report per packet
//  cfg       | cfg_valid/ready, cfg_index, cfg_data | one register write
//
// One byte is accepted per cycle while not stalled; each report is registered and
// is valid in the cycle after the ninth byte. The only stall source is the output
// register: s_axis_tready drops only while a report is held and m_axis_tready
// is low. rst (synchronous) clears byte count, tool tracker, enable and the output
// valid; the threshold returns to 10. Stored packet bytes are not cleared.
`include "assert_macros.svh"

module pen_digitizer_packet_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] in_range, [16:1] pos_x, [32:17] pos_y, [42:33] tip_pressure,
  // [43] touching, [44] side_button_a, [45] side_button_b, [46] eraser_active,
  // [47] zero
  output pdpp_pkg::pen_report_t m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  import pdpp_pkg::*;

  logic        enabled;
  logic [9:0]  touch_threshold;
  logic [3:0]  byte_count;
  logic [7:0]  packet_bytes [0:7];
  logic        tool_near;
  logic        eraser_latched;

  logic        in_acc;
  logic        byte_take;
  logic        pkt_done;
  logic        tool_near_next;
  logic        eraser_latched_next;
  logic        prox;
  logic [16:0] x_wide;
  logic [16:0] y_wide;
  logic [9:0]  pressure;
  pen_report_t report_next;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  // a data byte with no packet open is dropped
  assign byte_take     = in_acc && enabled && (s_axis_tdata[7] || (byte_count != 4'd0));
  assign pkt_done      = byte_take && !s_axis_tdata[7] && (byte_count == PKT_LAST_IDX);

  always_comb begin
    prox   = packet_bytes[0][5];
    x_wide = {packet_bytes[1], 9'd0} | {7'd0, packet_bytes[2], 2'd0}
           | {15'd0, packet_bytes[6][6:5]};
    y_wide = {packet_bytes[3], 9'd0} | {7'd0, packet_bytes[4], 2'd0}
           | {15'd0, packet_bytes[6][4:3]};
    pressure = {packet_bytes[6][2:0], 7'd0} | {2'd0, packet_bytes[5]};

    tool_near_next      = tool_near;
    eraser_latched_next = eraser_latched;
    if (!tool_near && prox) begin
      tool_near_next      = 1'b1;
      eraser_latched_next = packet_bytes[0][2];
    end else if (tool_near && !prox) begin
      tool_near_next      = 1'b0;
      eraser_latched_next = 1'b0;
    end

    report_next.pad           = 1'b0;
    report_next.eraser_active = eraser_latched_next;
    report_next.side_button_b = packet_bytes[0][2] && !eraser_latched_next;
    report_next.side_button_a = packet_bytes[0][1] && !eraser_latched_next;
    report_next.touching      = pressure > touch_threshold;
    report_next.tip_pressure  = pressure;
    report_next.pos_y         = y_wide[15:0];
    report_next.pos_x         = x_wide[15:0];
    report_next.in_range      = prox;
  end

  // Packet byte store: no reset, each entry written before a packet decodes it.
  always_ff @(posedge clk) begin
    if (byte_take && !pkt_done) begin
      if (s_axis_tdata[7]) begin
        packet_bytes[0] <= s_axis_tdata;
      end else begin
        packet_bytes[byte_count[2:0]] <= s_axis_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled         <= 1'b0;
      touch_threshold <= THRESH_RESET;
      byte_count      <= 4'd0;
      tool_near       <= 1'b0;
      eraser_latched  <= 1'b0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_REG_ENABLED: enabled         <= cfg_data[0];
          CFG_REG_THRESH:  touch_threshold <= cfg_data;
          default:         ;
        endcase
      end

      if (byte_take) begin
        if (pkt_done) begin
          byte_count     <= 4'd0;
          tool_near      <= tool_near_next;
          eraser_latched <= eraser_latched_next;
        end else if (s_axis_tdata[7]) begin
          byte_count <= 4'd1;
        end else begin
          byte_count <= byte_count + 4'd1;
        end
      end

      // hold the report until taken; load a new one on packet completion
      if (pkt_done) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_done) begin
      m_axis_tdata <= report_next;
    end
  end

  `PDPP_ASSERT_ALWAYS(a_reset_clears_valid, rst |=> !m_axis_tvalid, "report valid after reset")
  `PDPP_ASSERT(a_count_range, byte_count <= PKT_LAST_IDX, "byte count past packet end")
  `PDPP_ASSERT(a_eraser_needs_tool, eraser_latched |-> tool_near, "eraser set without pen near")
  `PDPP_ASSERT(a_report_source, $rose(m_axis_tvalid) |-> $past(pkt_done), "report without ninth byte")
  `PDPP_ASSERT(a_halt_holds, (!enabled) |=> $stable(byte_count), "byte count moved while halted")

endmodule
